// ----- sv/mes_pkg.sv -----
`default_nettype none
package mes_pkg;
   // result format: unsigned q1.16
   localparam int SMOOTH_WIDTH = 17;
   localparam int QUO_BITS = 16;
   localparam logic [SMOOTH_WIDTH-1:0] SMOOTH_ONE = 17'h10000;
   localparam int RESET_MAX_ITER = 50;
endpackage
`default_nettype wire

// ----- sv/mes_front.sv -----
`default_nettype none
module mes_front #(
   parameter int COORD_WIDTH = 32,
   parameter int ITER_WIDTH = 10
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   output logic                               full,
   input  wire logic signed [COORD_WIDTH-1:0] c_real,
   input  wire logic signed [COORD_WIDTH-1:0] c_imag,
   input  wire logic [ITER_WIDTH-1:0]         max_iter,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic signed [COORD_WIDTH-1:0]      out_real,
   output logic signed [COORD_WIDTH-1:0]      out_imag,
   output logic                               out_zero_limit
);
   import mes_pkg::*;

   // two-entry queue between the input side and the iteration engine
   logic signed [COORD_WIDTH-1:0] real_mem_ff [2];
   logic signed [COORD_WIDTH-1:0] imag_mem_ff [2];
   logic                          zl_mem_ff   [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok, pop_ok;

   assign full      = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign push_ok   = push && !full;
   assign pop_ok    = out_valid && out_ready;

   assign out_real       = real_mem_ff[rd_ptr_ff];
   assign out_imag       = imag_mem_ff[rd_ptr_ff];
   assign out_zero_limit = zl_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // a zero limit means no update runs at all
   always_ff @(posedge clock) begin
      if (push_ok) begin
         real_mem_ff[wr_ptr_ff] <= c_real;
         imag_mem_ff[wr_ptr_ff] <= c_imag;
         zl_mem_ff[wr_ptr_ff]   <= (max_iter == '0);
      end
   end
endmodule
`default_nettype wire

// ----- sv/mes_iter.sv -----
`default_nettype none
module mes_iter #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS = 28,
   parameter int ITER_WIDTH = 10
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [ITER_WIDTH-1:0]         max_iter,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic signed [COORD_WIDTH-1:0] in_real,
   input  wire logic signed [COORD_WIDTH-1:0] in_imag,
   input  wire logic                          in_zero_limit,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic                               out_escaped,
   output logic [ITER_WIDTH-1:0]              out_count
);
   import mes_pkg::*;

   // z stays within +-2 once kept, so it needs three integer bits
   localparam int ZW = FRAC_BITS + 3;
   localparam int PW = 2 * ZW;
   localparam int SW = ((COORD_WIDTH > FRAC_BITS + 7) ? COORD_WIDTH : FRAC_BITS + 7) + 1;
   localparam logic signed [SW-1:0] TWO  = SW'(1) <<< (FRAC_BITS + 1);
   localparam logic signed [SW-1:0] NTWO = -TWO;
   localparam logic [PW:0] FOUR = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

   typedef enum logic [1:0] {
      S_IDLE,
      S_UPD,
      S_MUL,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic signed [COORD_WIDTH-1:0] cr_ff, cr_in, ci_ff, ci_in;
   logic signed [ZW-1:0] re_ff, re_in, im_ff, im_in;
   logic signed [PW-1:0] rr_ff, rr_in, ii_ff, ii_in, p_ff, p_in;
   logic [ITER_WIDTH-1:0] cnt_ff, cnt_in;
   logic first_ff, first_in;
   logic esc_ff, esc_in;

   logic signed [PW:0] diff, twop;
   logic signed [SW-1:0] s_val, t_val, nre, nim;
   logic [PW:0] mag_sum;
   logic sum_gt, out_bnd;
   logic [ITER_WIDTH:0] next_i;

   assign in_ready    = (state_ff == S_IDLE);
   assign out_valid   = (state_ff == S_DONE);
   assign out_escaped = esc_ff;
   assign out_count   = cnt_ff;

   always_comb begin
      diff    = (PW + 1)'(rr_ff) - (PW + 1)'(ii_ff);
      twop    = {p_ff, 1'b0};
      s_val   = SW'(diff >>> FRAC_BITS);
      t_val   = SW'(twop >>> FRAC_BITS);
      nre     = s_val + SW'(cr_ff);
      nim     = t_val + SW'(ci_ff);
      out_bnd = (nre > TWO) || (nre < NTWO) || (nim > TWO) || (nim < NTWO);
      mag_sum = {1'b0, rr_ff} + {1'b0, ii_ff};
      sum_gt  = (mag_sum > FOUR);
      next_i  = (ITER_WIDTH + 1)'(cnt_ff) + (ITER_WIDTH + 1)'(1);
   end

   always_comb begin
      state_in = state_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      re_in    = re_ff;
      im_in    = im_ff;
      rr_in    = rr_ff;
      ii_in    = ii_ff;
      p_in     = p_ff;
      cnt_in   = cnt_ff;
      first_in = first_ff;
      esc_in   = esc_ff;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cr_in    = in_real;
               ci_in    = in_imag;
               rr_in    = '0;
               ii_in    = '0;
               p_in     = '0;
               cnt_in   = '0;
               first_in = 1'b1;
               esc_in   = 1'b0;
               state_in = in_zero_limit ? S_DONE : S_UPD;
            end
         end
         S_UPD: begin
            // check of the previous update's magnitude comes first
            if (!first_ff && sum_gt) begin
               esc_in   = 1'b1;
               state_in = S_DONE;
            end else if (!first_ff && next_i == (ITER_WIDTH + 1)'(max_iter)) begin
               esc_in   = 1'b0;
               cnt_in   = max_iter;
               state_in = S_DONE;
            end else begin
               cnt_in   = first_ff ? cnt_ff : next_i[ITER_WIDTH-1:0];
               first_in = 1'b0;
               if (out_bnd) begin
                  esc_in   = 1'b1;
                  state_in = S_DONE;
               end else begin
                  re_in    = nre[ZW-1:0];
                  im_in    = nim[ZW-1:0];
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            rr_in    = re_ff * re_ff;
            ii_in    = im_ff * im_ff;
            p_in     = re_ff * im_ff;
            state_in = S_UPD;
         end
         S_DONE: begin
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         first_ff <= 1'b0;
         esc_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
         esc_ff   <= esc_in;
         cnt_ff   <= cnt_in;
      end
      cr_ff <= cr_in;
      ci_ff <= ci_in;
      re_ff <= re_in;
      im_ff <= im_in;
      rr_ff <= rr_in;
      ii_ff <= ii_in;
      p_ff  <= p_in;
   end
endmodule
`default_nettype wire

// ----- sv/mes_smooth.sv -----
`default_nettype none
module mes_smooth #(
   parameter int ITER_WIDTH = 10,
   parameter int SMOOTH_OFFSET = 50
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire logic                              in_escaped,
   input  wire logic [ITER_WIDTH-1:0]             in_count,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [mes_pkg::SMOOTH_WIDTH-1:0]       rsp_smooth_value,
   output logic                                   rsp_escaped,
   output logic [ITER_WIDTH-1:0]                  rsp_iteration_count
);
   import mes_pkg::*;

   localparam int OW = $clog2(SMOOTH_OFFSET + 1);
   localparam int DW = ((ITER_WIDTH > OW) ? ITER_WIDTH : OW) + 1;
   localparam logic [3:0] LAST_STEP = 4'(QUO_BITS - 1);

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_OUT
   } div_state_type;

   div_state_type state_ff, state_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0] rem_ff, rem_in;
   logic [QUO_BITS-1:0] quo_ff, quo_in;
   logic [3:0] step_ff, step_in;
   logic [SMOOTH_WIDTH-1:0] smooth_ff, smooth_in;
   logic esc_ff, esc_in;
   logic [ITER_WIDTH-1:0] cnt_ff, cnt_in;
   logic [DW:0] rem2;
   logic take;

   assign in_ready            = (state_ff == DIV_IDLE);
   assign rsp_empty           = (state_ff != DIV_OUT);
   assign rsp_smooth_value    = smooth_ff;
   assign rsp_escaped         = esc_ff;
   assign rsp_iteration_count = cnt_ff;

   // restoring division of count by count + offset, one quotient bit a cycle
   always_comb begin
      rem2 = {rem_ff[DW-1:0], 1'b0};
      take = (rem2 >= {1'b0, den_ff});
   end

   always_comb begin
      state_in  = state_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      smooth_in = smooth_ff;
      esc_in    = esc_ff;
      cnt_in    = cnt_ff;
      case (state_ff)
         DIV_IDLE: begin
            if (in_valid) begin
               esc_in  = in_escaped;
               cnt_in  = in_count;
               rem_in  = (DW + 1)'(in_count);
               den_in  = DW'(in_count) + DW'(SMOOTH_OFFSET);
               quo_in  = '0;
               step_in = '0;
               if (in_escaped) begin
                  state_in = DIV_RUN;
               end else begin
                  smooth_in = SMOOTH_ONE;
                  state_in  = DIV_OUT;
               end
            end
         end
         DIV_RUN: begin
            rem_in  = take ? (rem2 - {1'b0, den_ff}) : rem2;
            quo_in  = {quo_ff[QUO_BITS-2:0], take};
            step_in = step_ff + 4'd1;
            if (step_ff == LAST_STEP) begin
               smooth_in = {1'b0, quo_ff[QUO_BITS-2:0], take};
               state_in  = DIV_OUT;
            end
         end
         DIV_OUT: begin
            if (rsp_pop) begin
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      smooth_ff <= smooth_in;
      esc_ff    <= esc_in;
      cnt_ff    <= cnt_in;
   end
endmodule
`default_nettype wire

// ----- sv/mandelbrot_escape_smooth.sv -----
// the time from accept to result depends on the path: an update that leaves the +-2 box, a
// trip of the magnitude test alone, a point that stays inside up to the limit, or a zero limit
// the iteration engine works on one point at a time, and the 16-step divider on one escaped
// point at a time; the slower part sets the rate
// a two-word input queue takes new points while the engine is busy
// reset: synchronous, clears queues and state machines, limit returns to 50
`default_nettype none
module mandelbrot_escape_smooth #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS = 28,
   parameter int ITER_WIDTH = 10,
   parameter int SMOOTH_OFFSET = 50
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic signed [COORD_WIDTH-1:0] req_c_real,
   input  wire logic signed [COORD_WIDTH-1:0] req_c_imag,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [mes_pkg::SMOOTH_WIDTH-1:0]   rsp_smooth_value,
   output logic                               rsp_escaped,
   output logic [ITER_WIDTH-1:0]              rsp_iteration_count,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ITER_WIDTH-1:0]         csr_wdata
);
   import mes_pkg::*;

   logic [ITER_WIDTH-1:0] max_iter_ff;
   logic f_valid, f_ready, f_zl;
   logic signed [COORD_WIDTH-1:0] f_real, f_imag;
   logic b_valid, b_ready, b_esc;
   logic [ITER_WIDTH-1:0] b_cnt;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= ITER_WIDTH'(RESET_MAX_ITER);
      end else if (csr_valid && csr_ready) begin
         max_iter_ff <= csr_wdata;
      end
   end

   mes_front #(
      .COORD_WIDTH(COORD_WIDTH),
      .ITER_WIDTH(ITER_WIDTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .push(req_push),
      .full(req_full),
      .c_real(req_c_real),
      .c_imag(req_c_imag),
      .max_iter(max_iter_ff),
      .out_valid(f_valid),
      .out_ready(f_ready),
      .out_real(f_real),
      .out_imag(f_imag),
      .out_zero_limit(f_zl)
   );

   mes_iter #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS(FRAC_BITS),
      .ITER_WIDTH(ITER_WIDTH)
   ) u_iter (
      .clock(clock),
      .reset(reset),
      .max_iter(max_iter_ff),
      .in_valid(f_valid),
      .in_ready(f_ready),
      .in_real(f_real),
      .in_imag(f_imag),
      .in_zero_limit(f_zl),
      .out_valid(b_valid),
      .out_ready(b_ready),
      .out_escaped(b_esc),
      .out_count(b_cnt)
   );

   mes_smooth #(
      .ITER_WIDTH(ITER_WIDTH),
      .SMOOTH_OFFSET(SMOOTH_OFFSET)
   ) u_smooth (
      .clock(clock),
      .reset(reset),
      .in_valid(b_valid),
      .in_ready(b_ready),
      .in_escaped(b_esc),
      .in_count(b_cnt),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_smooth_value(rsp_smooth_value),
      .rsp_escaped(rsp_escaped),
      .rsp_iteration_count(rsp_iteration_count)
   );
endmodule
`default_nettype wire

// ----- sv/mes_checker.sv -----
`default_nettype none
module mes_checker #(
   parameter int ITER_WIDTH = 10
) (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_full,
   input wire logic                              rsp_empty,
   input wire logic                              rsp_pop,
   input wire logic [mes_pkg::SMOOTH_WIDTH-1:0]  rsp_smooth_value,
   input wire logic                              rsp_escaped,
   input wire logic [ITER_WIDTH-1:0]             rsp_iteration_count
);
   import mes_pkg::*;

   // inside points always report exactly one
   a_inside_one: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_escaped |-> rsp_smooth_value == SMOOTH_ONE)
      else $error("inside word without smooth value of one");

   a_escape_below_one: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_escaped |-> rsp_smooth_value < SMOOTH_ONE)
      else $error("escaped word with smooth value not below one");

   // escape at the first update gives zero
   a_escape_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_escaped && rsp_iteration_count == '0 |-> rsp_smooth_value == '0)
      else $error("escape at first update with nonzero smooth value");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_smooth_value)
         && $stable(rsp_escaped) && $stable(rsp_iteration_count))
      else $error("waiting result word changed");

   a_reset: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");
endmodule

bind mandelbrot_escape_smooth mes_checker #(.ITER_WIDTH(ITER_WIDTH)) u_mes_checker (.*);
`default_nettype wire

// ----- tb/tb_mandelbrot_escape_smooth.sv -----
`timescale 1ns / 1ps
module tb_mandelbrot_escape_smooth;
   import mes_pkg::*;

   localparam int COORD_W = 32;
   localparam int FRAC_W = 28;
   localparam int ITER_W = 10;
   localparam int OFFSET = 50;
   localparam logic [63:0] TWO_FIX = 64'd1 << (FRAC_W + 1);
   localparam logic [127:0] FOUR_SQ = 128'd1 << (2 * FRAC_W + 2);

   typedef struct packed {
      logic [SMOOTH_WIDTH-1:0] smooth;
      logic                    escaped;
      logic [ITER_W-1:0]       count;
   } escape_word_type;

   typedef struct {
      logic [COORD_W-1:0] c_re;
      logic [COORD_W-1:0] c_im;
      bit                 typed;
      escape_word_type    word;
   } point_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_push = 0;
   logic req_full;
   logic signed [COORD_W-1:0] req_c_real = '0;
   logic signed [COORD_W-1:0] req_c_imag = '0;
   logic rsp_empty;
   logic rsp_pop = 0;
   logic [SMOOTH_WIDTH-1:0] rsp_smooth_value;
   logic rsp_escaped;
   logic [ITER_W-1:0] rsp_iteration_count;
   logic csr_valid = 0;
   logic csr_ready;
   logic [ITER_W-1:0] csr_wdata = '0;

   mandelbrot_escape_smooth #(
      .COORD_WIDTH(COORD_W), .FRAC_BITS(FRAC_W), .ITER_WIDTH(ITER_W),
      .SMOOTH_OFFSET(OFFSET)
   ) u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_c_real(req_c_real), .req_c_imag(req_c_imag),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_smooth_value(rsp_smooth_value), .rsp_escaped(rsp_escaped),
      .rsp_iteration_count(rsp_iteration_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   escape_word_type pending_words[$];
   logic [ITER_W-1:0] iter_limit = ITER_W'(RESET_MAX_ITER);
   bit no_idle = 0;
   int unsigned mismatches = 0;
   int unsigned points_sent = 0;
   int unsigned words_checked = 0;
   int unsigned limits_used = 1;
   int unsigned escapes_seen = 0;

   function automatic logic [63:0] mag64(logic signed [63:0] x);
      return x[63] ? 64'd0 - x : x;
   endfunction

   function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
                                                  logic signed [63:0] b);
      logic [64:0] w;
      w = {a[63], a} + {b[63], b};
      if (w[64:63] == 2'b01) return {1'b0, {63{1'b1}}};
      if (w[64:63] == 2'b10) return {1'b1, 63'd0};
      return w[63:0];
   endfunction

   function automatic escape_word_type predict_escape(logic signed [COORD_W-1:0] cr32,
                                                      logic signed [COORD_W-1:0] ci32,
                                                      logic [ITER_W-1:0] limit);
      logic signed [63:0] cr, ci, re, im, s, t, nre, nim;
      logic [127:0] rr, ii, d, p;
      logic [63:0] m_re, m_im;
      int unsigned i;
      bit gone;
      escape_word_type w;
      cr = cr32;
      ci = ci32;
      re = 0;
      im = 0;
      rr = 0;
      ii = 0;
      i = 0;
      gone = 0;
      while (i < limit && !gone) begin
         d = rr - ii;
         s = d[FRAC_W+63:FRAC_W];
         p = {64'd0, mag64(re)} * {64'd0, mag64(im)};
         p = p << 1;
         if (re[63] != im[63]) p = 128'd0 - p;
         t = p[FRAC_W+63:FRAC_W];
         nre = add_sat(s, cr);
         nim = add_sat(t, ci);
         m_re = mag64(nre);
         m_im = mag64(nim);
         if (m_re > TWO_FIX || m_im > TWO_FIX) begin
            gone = 1;
         end else begin
            rr = {64'd0, m_re} * {64'd0, m_re};
            ii = {64'd0, m_im} * {64'd0, m_im};
            if (rr + ii > FOUR_SQ) gone = 1;
            else begin
               re = nre;
               im = nim;
               i++;
            end
         end
      end
      if (gone) begin
         w.smooth = SMOOTH_WIDTH'((i << QUO_BITS) / (i + OFFSET));
         w.escaped = 1;
         w.count = ITER_W'(i);
      end else begin
         w.smooth = SMOOTH_ONE;
         w.escaped = 0;
         w.count = limit;
      end
      return w;
   endfunction

   function automatic int unsigned draw_gap();
      return no_idle ? 0 : $urandom_range(0, 7);
   endfunction

   // mostly points inside [-2, 2], sometimes raw noise over the whole range
   function automatic logic [COORD_W-1:0] draw_coord();
      logic signed [COORD_W-1:0] v;
      if ($urandom_range(0, 9) < 2) return $urandom;
      v = $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
      return v;
   endfunction

   task automatic send_point(logic [COORD_W-1:0] cr, logic [COORD_W-1:0] ci,
                             bit typed, escape_word_type word);
      int unsigned gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_push <= 0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1;
      req_c_real <= cr;
      req_c_imag <= ci;
      do @(posedge clock); while (req_full);
      pending_words.push_back(typed ? word : predict_escape(cr, ci, iter_limit));
      points_sent++;
   endtask

   task automatic drain_words();
      req_push <= 0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(logic [ITER_W-1:0] v);
      csr_valid <= 1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      iter_limit = v;
      limits_used++;
      @(posedge clock);
   endtask

   // result side: random pop stalls, compare against oldest expected word
   initial begin : rsp_side
      int unsigned stall;
      escape_word_type want, got;
      @(negedge reset);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_pop <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1;
         do @(posedge clock); while (rsp_empty);
         got = '{rsp_smooth_value, rsp_escaped, rsp_iteration_count};
         words_checked++;
         if (got.escaped) escapes_seen++;
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: smooth=%0d esc=%0d count=%0d",
                        got.smooth, got.escaped, got.count);
         end else begin
            want = pending_words.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp smooth=%0d esc=%0d count=%0d, ",
                            "got smooth=%0d esc=%0d count=%0d"},
                           want.smooth, want.escaped, want.count,
                           got.smooth, got.escaped, got.count);
            end
         end
      end
   end

   initial begin : watchdog
      #100_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : req_side
      point_row_type rows[$];
      escape_word_type esc0, inside50, inside0, inside_max;
      logic [ITER_W-1:0] limits[$];
      int unsigned n_items;
      esc0 = '{SMOOTH_WIDTH'(0), 1'b1, ITER_W'(0)};
      inside50 = '{SMOOTH_ONE, 1'b0, ITER_W'(RESET_MAX_ITER)};
      inside0 = '{SMOOTH_ONE, 1'b0, ITER_W'(0)};
      inside_max = '{SMOOTH_ONE, 1'b0, ITER_W'(1023)};

      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      rows = '{
         '{32'h0000_0000, 32'h0000_0000, 1, inside50},
         '{32'h7FFF_FFFF, 32'h0000_0000, 1, esc0},
         '{32'h8000_0000, 32'h8000_0000, 1, esc0},
         '{32'h0000_0000, 32'h7FFF_FFFF, 1, esc0},
         '{32'h8000_0000, 32'h0000_0000, 1, esc0},
         '{32'h7FFF_FFFF, 32'h8000_0000, 1, esc0},
         '{32'h2000_0001, 32'h0000_0000, 1, esc0},
         '{32'h0000_0000, 32'hDFFF_FFFF, 1, esc0},
         '{32'h2000_0000, 32'h0000_0000, 0, inside50},
         '{32'hE000_0000, 32'h0000_0000, 0, inside50},
         '{32'h0000_0000, 32'h2000_0000, 0, inside50},
         '{32'h0000_0000, 32'hE000_0000, 0, inside50},
         '{32'h1800_0000, 32'h1800_0000, 0, inside50},
         '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, inside50},
         '{32'h0000_0001, 32'h0000_0001, 0, inside50},
         '{32'h0400_0000, 32'h0000_0000, 0, inside50},
         '{32'h0401_0000, 32'h0000_0000, 0, inside50},
         '{32'hF400_0000, 32'h0199_999A, 0, inside50},
         '{32'h5555_5555, 32'hAAAA_AAAA, 0, inside50},
         '{32'hAAAA_AAAA, 32'h5555_5555, 0, inside50}
      };
      foreach (rows[k]) send_point(rows[k].c_re, rows[k].c_im, rows[k].typed, rows[k].word);
      drain_words();

      // zero limit: no update runs at all
      write_limit(ITER_W'(0));
      send_point(32'h0000_0000, 32'h0000_0000, 1, inside0);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 1, inside0);
      drain_words();
      write_limit(ITER_W'(1023));
      send_point(32'h0000_0000, 32'h0000_0000, 1, inside_max);
      drain_words();

      limits = '{1, 1023, 0, 7, 200, 50, 2, 511};
      repeat (6) limits.push_back(ITER_W'($urandom_range(1, 300)));
      foreach (limits[ph]) begin
         write_limit(limits[ph]);
         no_idle = (ph % 4 == 3);
         n_items = (limits[ph] > 400) ? 15 : 170;
         for (int unsigned k = 0; k < n_items; k++) begin
            // hold off until the block has drained once mid phase
            if (ph == 4 && k == n_items / 2) begin
               req_push <= 0;
               @(posedge clock);
               while (pending_words.size() != 0) @(posedge clock);
            end
            send_point(draw_coord(), draw_coord(), 0, inside50);
         end
         drain_words();
      end
      no_idle = 0;

      req_push <= 0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("sent %0d points under %0d limit settings, %0d words checked, %0d escaped",
               points_sent, limits_used, words_checked, escapes_seen);
      $display("limits covered 0, 1, 1023 and reset default; mismatches %0d", mismatches);
      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
